// File: sv/tsdod_pkg.sv
// Shared types, codes and widths for the delta-of-delta varint timestamp encoder.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package tsdod_pkg;

  localparam int STAMP_W = 64;
  localparam int GAP_W   = 63;
  localparam int BYTE_W  = 8;
  localparam int GROUP_W = 7;

  typedef logic signed [STAMP_W-1:0] stamp_t;
  typedef logic [GAP_W-1:0]          gap_t;
  typedef logic [BYTE_W-1:0]         code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ORDER  = 2'd1,
    ST_GAP    = 2'd2
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic calc;
    logic diff;
    logic shift;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic chunk;
    logic err;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: sv/tsdod_ctrl.sv
// Sequencing state machine for the timestamp encoder: load, check, difference, emit.
// Depends on tsdod_pkg for the command and status structs.
`default_nettype none
module tsdod_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tsdod_pkg::dp_cmd_t     cmd,
  input  wire tsdod_pkg::dp_stat_t stat
);
  import tsdod_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIFF = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (stat.chunk) begin
          state_nxt = S_IDLE;
        end else if (stat.err) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.shift = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/tsdod_dp.sv
// Datapath for the timestamp encoder: chunk state, gap checks, zigzag and varint shifter.
// Depends on tsdod_pkg for widths, status codes and the command and status structs.
`default_nettype none
module tsdod_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tsdod_pkg::stamp_t   in_stamp,
  input  wire logic                in_chunk_start,
  input  wire tsdod_pkg::dp_cmd_t  cmd,
  output tsdod_pkg::dp_stat_t      stat,
  output tsdod_pkg::code_t         out_code_byte,
  output logic                     out_final_byte,
  output tsdod_pkg::status_t       out_status
);
  import tsdod_pkg::*;

  stamp_t                stamp_r;
  logic                  start_r;
  stamp_t                prior_r, prior_nxt;
  gap_t                  pgap_r, pgap_nxt;
  logic                  have_r, have_nxt;
  logic [STAMP_W-1:0]    gap_r, gap_nxt;
  status_t               err_r, err_nxt;
  logic [STAMP_W-1:0]    zz_r, zz_nxt;

  logic                  chunk;
  logic                  order_bad;
  logic [STAMP_W-1:0]    gap_calc;
  logic [STAMP_W-1:0]    diff;
  logic                  more;

  assign chunk     = start_r || !have_r;
  assign order_bad = (stamp_r <= prior_r);
  assign gap_calc  = STAMP_W'(stamp_r) - STAMP_W'(prior_r);
  assign diff      = gap_r - {1'b0, pgap_r};
  assign more      = |zz_r[STAMP_W-1:GROUP_W];

  always_comb begin
    prior_nxt = prior_r;
    pgap_nxt  = pgap_r;
    have_nxt  = have_r;
    gap_nxt   = gap_r;
    err_nxt   = err_r;
    zz_nxt    = zz_r;
    if (cmd.calc) begin
      if (chunk) begin
        prior_nxt = stamp_r;
        pgap_nxt  = '0;
        have_nxt  = 1'b1;
      end else begin
        gap_nxt = gap_calc;
        if (order_bad) begin
          err_nxt = ST_ORDER;
        end else if (gap_calc[STAMP_W-1]) begin
          err_nxt = ST_GAP;
        end else begin
          err_nxt = ST_OK;
        end
      end
    end
    if (cmd.diff) begin
      zz_nxt    = {diff[STAMP_W-2:0], 1'b0} ^ {STAMP_W{diff[STAMP_W-1]}};
      prior_nxt = stamp_r;
      pgap_nxt  = gap_r[GAP_W-1:0];
    end
    if (cmd.shift) begin
      zz_nxt = zz_r >> GROUP_W;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= '0;
      pgap_r  <= '0;
      have_r  <= 1'b0;
      err_r   <= ST_OK;
    end else begin
      prior_r <= prior_nxt;
      pgap_r  <= pgap_nxt;
      have_r  <= have_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stamp_r <= in_stamp;
      start_r <= in_chunk_start;
    end
    gap_r <= gap_nxt;
    zz_r  <= zz_nxt;
  end

  assign stat.chunk = chunk;
  assign stat.err   = order_bad || gap_calc[STAMP_W-1];
  assign stat.last  = (err_r != ST_OK) || !more;

  assign out_status     = err_r;
  assign out_final_byte = (err_r != ST_OK) || !more;
  assign out_code_byte  = (err_r != ST_OK) ? '0 : {more, zz_r[GROUP_W-1:0]};

endmodule
`default_nettype wire

// File: sv/timestamp_delta_of_delta_varint_encoder.sv
// Top level of the delta-of-delta zigzag varint timestamp encoder.
// Depends on tsdod_pkg, tsdod_ctrl and tsdod_dp.
//
// One timestamp is taken at a time. An item flagged chunk_start (or any item
// while no chunk is open) is stored and emits nothing; it is taken in the idle
// state and stored in the check state. Any other item is taken and then order
// and gap checked. An error then gives one result byte 0 with final_byte set
// and the status code, and leaves the chunk state as it was. A good item then
// passes the difference and zigzag step and emits its result bytes; the emit
// loop sends one varint byte per cycle while the sink is ready, from a 64-bit
// shift register.
`default_nettype none
module timestamp_delta_of_delta_varint_encoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tsdod_pkg::stamp_t  in_stamp,
  input  wire logic               in_chunk_start,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tsdod_pkg::code_t        out_code_byte,
  output logic                    out_final_byte,
  output tsdod_pkg::status_t      out_status
);
  import tsdod_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsdod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tsdod_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stamp       (in_stamp),
    .in_chunk_start (in_chunk_start),
    .cmd            (cmd),
    .stat           (stat),
    .out_code_byte  (out_code_byte),
    .out_final_byte (out_final_byte),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for timestamp_delta_of_delta_varint_encoder.
// Depends on tsdod_pkg and the encoder RTL; predicts varint bytes from its own copy of chunk state.
module testbench;
  import tsdod_pkg::*;

  typedef struct packed {
    code_t   code;
    logic    fin;
    status_t st;
  } coded_byte_t;

  localparam stamp_t STAMP_MIN = {1'b1, 63'd0};
  localparam stamp_t STAMP_MAX = {1'b0, {63{1'b1}}};
  localparam int ITEMS_PER_PHASE = 112;

  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  stamp_t  in_stamp = '0;
  logic    in_chunk_start = 1'b0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  code_t   out_code_byte;
  logic    out_final_byte;
  status_t out_status;

  coded_byte_t pending_bytes[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  stamp_t last_stamp = '0;
  gap_t   last_gap = '0;
  logic   chunk_open = 1'b0;

  timestamp_delta_of_delta_varint_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stamp       (in_stamp),
    .in_chunk_start (in_chunk_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_byte  (out_code_byte),
    .out_final_byte (out_final_byte),
    .out_status     (out_status)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void push_byte(code_t code, logic fin, status_t st);
    coded_byte_t b;
    b.code = code;
    b.fin  = fin;
    b.st   = st;
    pending_bytes.insert(pending_bytes.size(), b);
  endfunction

  function automatic void encode_point(stamp_t stamp, logic start);
    logic [63:0] gap;
    logic [63:0] diff;
    logic [63:0] zz;
    code_t       b;
    int          n;
    if (start || !chunk_open) begin
      last_stamp = stamp;
      last_gap   = '0;
      chunk_open = 1'b1;
      return;
    end
    if (stamp <= last_stamp) begin
      push_byte('0, 1'b1, ST_ORDER);
      return;
    end
    gap = stamp - last_stamp;
    if (gap[63]) begin
      push_byte('0, 1'b1, ST_GAP);
      return;
    end
    diff = gap - {1'b0, last_gap};
    zz = (diff << 1) ^ {64{diff[63]}};
    n = 0;
    do begin
      b = {1'b0, zz[6:0]};
      zz = zz >> 7;
      if (zz != 0) b[7] = 1'b1;
      push_byte(b, zz == 0, ST_OK);
      n++;
    end while (zz != 0 && n < 10);
    last_stamp = stamp;
    last_gap   = gap[62:0];
  endfunction

  always @(posedge clk) begin
    coded_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected byte code=%h final=%b status=%0d", $realtime,
                   out_code_byte, out_final_byte, out_status);
      end else begin
        want = pending_bytes.pop_front();
        if (out_code_byte !== want.code || out_final_byte !== want.fin ||
            out_status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected code=%h final=%b status=%0d, got %h %b %0d",
                     $realtime, want.code, want.fin, want.st,
                     out_code_byte, out_final_byte, out_status);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer_point(stamp_t stamp, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stamp       <= stamp;
    in_chunk_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_point(stamp, start);
    @(negedge clk);
  endtask

  task automatic next_random_point(output stamp_t stamp, output logic start);
    int          pick;
    logic [63:0] gap;
    pick  = $urandom_range(99);
    start = 1'b0;
    gap   = 64'd1;
    if (pick < 8) begin
      start = 1'b1;
      stamp = {$urandom, $urandom};
      if ($urandom_range(3) == 0) stamp[62:40] = stamp[63] ? '0 : '1;
    end else if (pick < 14) begin
      stamp = {$urandom, $urandom};
      start = ($urandom_range(9) == 0);
    end else if (pick < 20) begin
      stamp = last_stamp - 64'($urandom_range(5));
    end else begin
      case ($urandom_range(3))
        0: gap = {1'b0, last_gap} + 64'($urandom_range(8)) - 64'd4;
        1: gap = 64'($urandom_range(255, 1));
        2: gap = {$urandom, $urandom} >> $urandom_range(63, 1);
        default: gap = {1'b0, last_gap};
      endcase
      if (gap == 0 || gap[63]) gap = 64'd1;
      stamp = last_stamp + gap;
    end
  endtask

  task automatic test_open_chunk_and_lengths();
    offer_point(64'sd100, 1'b0);
    offer_point(64'sd110, 1'b0);
    offer_point(64'sd120, 1'b0);
    offer_point(64'sd125, 1'b0);
    offer_point(64'sd1000, 1'b1);
    offer_point(64'sd1064, 1'b0);
    offer_point(64'sd1128, 1'b0);
    offer_point(64'sd1129, 1'b0);
  endtask

  task automatic test_order_and_gap_errors();
    offer_point(64'sd1129, 1'b0);
    offer_point(64'sd1000, 1'b0);
    offer_point(STAMP_MIN, 1'b1);
    offer_point(STAMP_MAX, 1'b0);
    offer_point(-64'sd1, 1'b0);
    offer_point(64'sd0, 1'b0);
    offer_point(STAMP_MAX, 1'b1);
    offer_point(STAMP_MAX, 1'b0);
    offer_point(STAMP_MIN, 1'b0);
    offer_point(-64'sd1000, 1'b1);
    offer_point(-64'sd900, 1'b0);
    offer_point(-64'sd850, 1'b0);
  endtask

  task automatic test_random_traffic(int idle_pct, int stall);
    stamp_t stamp;
    logic   start;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (ITEMS_PER_PHASE) begin
      next_random_point(stamp, start);
      offer_point(stamp, start);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_open_chunk_and_lengths();
    test_order_and_gap_errors();
    test_random_traffic(0, 0);
    test_random_traffic(73, 0);
    test_random_traffic(0, 73);
    test_random_traffic(26, 26);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
